FILE: hdl/rsd_pkg.sv
// Shared constants and result codes for the RTP stream deframer.
package rsd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hE1;
  localparam logic [7:0] MAGIC_R     = 8'h72;
  localparam logic [7:0] MAGIC_T     = 8'h74;
  localparam logic [7:0] MAGIC_P     = 8'h70;
  localparam logic [7:0] MAGIC_NUL   = 8'h00;

  localparam int unsigned POS_W     = 16;
  localparam logic [15:0] MIN_FRAME = 16'd20;

  localparam int unsigned KIND_W    = 2;
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // output tdata and tuser widths
  localparam int unsigned TDATA_W = 112;
  localparam int unsigned TUSER_W = 3;

endpackage

FILE: hdl/rtp_stream_deframer.sv
// Framed RTP byte-stream deframer: sync hunt, header parse, payload output.
//
// Input: one received byte per transaction on s_axis (tdata = rx_byte).
// The block hunts for the sync pair FF E1, reads the little-endian frame
// length, checks the "rtp\0" tag, collects the 12-byte RTP fixed header and
// then passes each payload byte out on m_axis together with the header
// fields of its frame. tlast marks the final result of a frame; tuser holds
// the result kind and the first-byte flag. A frame of exactly 20 bytes gives
// one empty end result, a length below 20 one error result, after which
// hunting resumes.
// Throughput: one byte per clock; the byte is parsed in the cycle it is
// taken and its result is registered, so a result appears on m_axis in the
// cycle after the byte is accepted. Bytes that give no result just advance
// the parser. s_axis_tready stays high while the output register is empty
// or being drained; a stalled receiver holds the result and blocks input.
// Reset (rst_ni low, asynchronous) clears the parser to hunting, the held
// header fields to zero and drops any pending result.
module rtp_stream_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] payload_byte, [23:8] sequence_number, [30:24] payload_type,
  // [62:31] time_stamp, [94:63] source_id, [110:95] payload_length, [111] 0
  output logic [rsd_pkg::TDATA_W-1:0] m_axis_tdata,
  // [1:0] kind, [2] first_flag
  output logic [rsd_pkg::TUSER_W-1:0] m_axis_tuser,
  output logic                        m_axis_tlast    // last_flag
);

  logic                      sync_q, sync_d;
  logic                      in_frame_q, in_frame_d;
  logic [rsd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]               len_q, len_d;
  logic [15:0]               seq_q, seq_d;
  logic [6:0]                ptype_q, ptype_d;
  logic [31:0]               stamp_q, stamp_d;
  logic [31:0]               ssrc_q, ssrc_d;

  logic                      ovalid_q, ovalid_d;
  logic [rsd_pkg::TDATA_W-1:0] odata_q, odata_d;
  logic [rsd_pkg::TUSER_W-1:0] ouser_q, ouser_d;
  logic                      olast_q, olast_d;

  logic       accept;
  logic       res_valid;
  logic [1:0] res_kind;
  logic       res_first;
  logic       res_last;
  logic       res_hdr;
  logic [7:0] b;
  logic [7:0] magic;
  logic [15:0] pos_inc;
  logic [15:0] plen;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = pos_q + 16'd1;

  always_comb begin
    case (pos_q[1:0])
      2'd0:    magic = rsd_pkg::MAGIC_R;
      2'd1:    magic = rsd_pkg::MAGIC_T;
      2'd2:    magic = rsd_pkg::MAGIC_P;
      default: magic = rsd_pkg::MAGIC_NUL;
    endcase
  end

  // parser: next state and the result caused by this byte
  always_comb begin
    sync_d     = sync_q;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    seq_d      = seq_q;
    ptype_d    = ptype_q;
    stamp_d    = stamp_q;
    ssrc_d     = ssrc_q;
    res_valid  = 1'b0;
    res_kind   = rsd_pkg::KIND_DATA;
    res_first  = 1'b0;
    res_last   = 1'b0;
    res_hdr    = 1'b1;

    if (!in_frame_q) begin
      if (sync_q) begin
        sync_d = 1'b0;
        if (b == rsd_pkg::SYNC_SECOND) begin
          in_frame_d = 1'b1;
          pos_d      = 16'd2;
          len_d      = 16'd0;
        end
      end else if (b == rsd_pkg::SYNC_FIRST) begin
        sync_d = 1'b1;
      end
    end else if (pos_q == 16'd2) begin
      len_d = {8'd0, b};
      pos_d = 16'd3;
    end else if (pos_q == 16'd3) begin
      len_d = {b, len_q[7:0]};
      pos_d = 16'd4;
    end else if (pos_q >= 16'd4 && pos_q <= 16'd7) begin
      if (b != magic) begin
        in_frame_d = 1'b0;
      end else if (pos_q == 16'd7 && len_q < rsd_pkg::MIN_FRAME) begin
        in_frame_d = 1'b0;
        res_valid  = 1'b1;
        res_kind   = rsd_pkg::KIND_ERROR;
        res_last   = 1'b1;
        res_hdr    = 1'b0;
      end else begin
        pos_d = pos_inc;
      end
    end else if (pos_q >= 16'd8 && pos_q < rsd_pkg::MIN_FRAME) begin
      if (pos_q == 16'd9) begin
        ptype_d = b[6:0];
      end else if (pos_q == 16'd10 || pos_q == 16'd11) begin
        seq_d = {seq_q[7:0], b};
      end else if (pos_q >= 16'd12 && pos_q <= 16'd15) begin
        stamp_d = {stamp_q[23:0], b};
      end else if (pos_q >= 16'd16) begin
        ssrc_d = {ssrc_q[23:0], b};
      end
      if (pos_q == 16'd19 && len_q == rsd_pkg::MIN_FRAME) begin
        in_frame_d = 1'b0;
        res_valid  = 1'b1;
        res_kind   = rsd_pkg::KIND_EMPTY;
        res_last   = 1'b1;
      end else begin
        pos_d = pos_inc;
      end
    end else begin
      // payload byte; pos + 1 cannot wrap before it reaches the length
      res_valid = 1'b1;
      res_kind  = rsd_pkg::KIND_DATA;
      res_first = (pos_q == rsd_pkg::MIN_FRAME);
      res_last  = (pos_inc >= len_q);
      if (res_last) begin
        in_frame_d = 1'b0;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  assign plen = len_q - rsd_pkg::MIN_FRAME;

  // header fields come from the updated registers, as the last header byte
  // of an empty frame lands in the source id
  always_comb begin
    if (res_hdr) begin
      odata_d = {1'b0, plen, ssrc_d, stamp_d, ptype_d, seq_d,
                 (res_kind == rsd_pkg::KIND_DATA) ? b : 8'd0};
    end else begin
      odata_d = '0;
    end
    ouser_d = {res_first, res_kind};
    olast_d = res_last;
    if (accept) begin
      ovalid_d = res_valid;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= 1'b0;
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      len_q      <= '0;
      seq_q      <= '0;
      ptype_q    <= '0;
      stamp_q    <= '0;
      ssrc_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (accept) begin
        sync_q     <= sync_d;
        in_frame_q <= in_frame_d;
        pos_q      <= pos_d;
        len_q      <= len_d;
        seq_q      <= seq_d;
        ptype_q    <= ptype_d;
        stamp_q    <= stamp_d;
        ssrc_q     <= ssrc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      odata_q <= odata_d;
      ouser_q <= ouser_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

FILE: hdl/rsd_checker.sv
// Port-level checks for the RTP stream deframer, bound to the top level.
module rsd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [rsd_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [rsd_pkg::TUSER_W-1:0] m_axis_tuser,
  input logic                        m_axis_tlast
);

  logic [1:0] kind;
  logic       first;

  assign kind  = m_axis_tuser[1:0];
  assign first = m_axis_tuser[2];

  // a held result keeps its contents
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // every result comes from an input transaction or is a held one
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $past(s_axis_tvalid && s_axis_tready) || $past(m_axis_tvalid && !m_axis_tready))
    else $error("result without input transaction");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      kind == rsd_pkg::KIND_DATA || kind == rsd_pkg::KIND_EMPTY ||
      kind == rsd_pkg::KIND_ERROR)
    else $error("undefined result kind");

  a_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == rsd_pkg::KIND_ERROR |->
      m_axis_tlast && !first && m_axis_tdata == '0)
    else $error("malformed length error result");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == rsd_pkg::KIND_EMPTY |->
      m_axis_tlast && !first && m_axis_tdata[7:0] == 8'd0 &&
      m_axis_tdata[110:95] == 16'd0)
    else $error("malformed empty frame result");

endmodule

bind rtp_stream_deframer rsd_checker u_rsd_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the RTP stream deframer, with random stream traffic.
module testbench;

  localparam longint CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 1150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        first_mark;
    logic        last_mark;
    logic [15:0] seq;
    logic [6:0]  ptype;
    logic [31:0] stamp;
    logic [31:0] ssrc;
    logic [15:0] plen;
  } deframe_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = 8'h00;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [rsd_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic [rsd_pkg::TUSER_W-1:0]  m_axis_tuser;
  logic                         m_axis_tlast;

  rtp_stream_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // stream bytes waiting to be sent, and results the deframer owes us
  logic [7:0]      pending_bytes[$];
  deframe_result_t expected_results[$];

  function automatic void add_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    b = pending_bytes[0];
    pending_bytes.delete(0);
    return b;
  endfunction

  function automatic void owe_result(input deframe_result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic deframe_result_t next_result();
    deframe_result_t r;
    r = expected_results[0];
    expected_results.delete(0);
    return r;
  endfunction

  // parser model state
  logic        sync_q;
  logic        in_frame_q;
  logic [15:0] pos_q;
  logic [15:0] len_q;
  logic [15:0] seq_q;
  logic [6:0]  ptype_q;
  logic [31:0] stamp_q;
  logic [31:0] source_q;

  int     frame_bytes;
  int     bytes_taken;
  int     results_checked;
  int     mismatches;
  int     kind_count[3];
  longint cycle_count;

  bit          in_taken;
  bit          out_taken;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_no_idle;
  bit          out_no_idle;

  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    case (idx)
      2'd0: return rsd_pkg::MAGIC_R;
      2'd1: return rsd_pkg::MAGIC_T;
      2'd2: return rsd_pkg::MAGIC_P;
      default: return rsd_pkg::MAGIC_NUL;
    endcase
  endfunction

  function automatic deframe_result_t framed_result(input logic [1:0] kind,
                                                    input logic [7:0] b,
                                                    input logic first_mark,
                                                    input logic last_mark);
    deframe_result_t r;
    r.kind       = kind;
    r.data       = b;
    r.first_mark = first_mark;
    r.last_mark  = last_mark;
    r.seq        = seq_q;
    r.ptype      = ptype_q;
    r.stamp      = stamp_q;
    r.ssrc       = source_q;
    r.plen       = len_q - rsd_pkg::MIN_FRAME;
    return r;
  endfunction

  // Advance the parser model by one byte and queue the result it owes.
  function automatic void parse_byte(input logic [7:0] b);
    deframe_result_t r;
    logic [15:0] k;
    logic last_mark;
    r = '0;
    k = pos_q - 16'd8;
    last_mark = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_q};
    if (!in_frame_q) begin
      if (sync_q) begin
        sync_q = 1'b0;
        if (b == rsd_pkg::SYNC_SECOND) begin
          in_frame_q = 1'b1;
          pos_q = 16'd2;
          len_q = 16'd0;
        end
      end else if (b == rsd_pkg::SYNC_FIRST) begin
        sync_q = 1'b1;
      end
    end else if (pos_q == 16'd2) begin
      len_q = {8'h00, b};
      pos_q = 16'd3;
    end else if (pos_q == 16'd3) begin
      len_q[15:8] = b;
      pos_q = 16'd4;
    end else if (pos_q < 16'd8) begin
      if (b != tag_byte(pos_q[1:0])) begin
        in_frame_q = 1'b0;
      end else if (pos_q == 16'd7 && len_q < rsd_pkg::MIN_FRAME) begin
        in_frame_q = 1'b0;
        r.kind = rsd_pkg::KIND_ERROR;
        r.last_mark = 1'b1;
        owe_result(r);
      end else begin
        pos_q = pos_q + 16'd1;
      end
    end else if (pos_q < rsd_pkg::MIN_FRAME) begin
      if (k == 16'd1) begin
        ptype_q = b[6:0];
      end else if (k == 16'd2 || k == 16'd3) begin
        seq_q = {seq_q[7:0], b};
      end else if (k >= 16'd4 && k <= 16'd7) begin
        stamp_q = {stamp_q[23:0], b};
      end else if (k >= 16'd8) begin
        source_q = {source_q[23:0], b};
      end
      if (k == 16'd11 && len_q == rsd_pkg::MIN_FRAME) begin
        in_frame_q = 1'b0;
        owe_result(framed_result(rsd_pkg::KIND_EMPTY, 8'h00, 1'b0, 1'b1));
      end else begin
        pos_q = pos_q + 16'd1;
      end
    end else begin
      owe_result(framed_result(rsd_pkg::KIND_DATA, b, pos_q == rsd_pkg::MIN_FRAME,
                               last_mark));
      if (last_mark) begin
        in_frame_q = 1'b0;
      end else begin
        pos_q = pos_q + 16'd1;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("MISMATCH result %0d: %s got 0x%0h, expected 0x%0h",
               results_checked, what, got, want);
    end
    mismatches++;
  endtask

  // Full frame: framing header, then for a length of 20 or more the 12-byte RTP header
  // and payload. hdr_fill < 0 gives a random RTP header, otherwise every header byte is hdr_fill.
  task automatic queue_frame(input int unsigned len, input int hdr_fill);
    logic [15:0] len16;
    logic [7:0]  b;
    len16 = len[15:0];
    add_byte(rsd_pkg::SYNC_FIRST);
    add_byte(rsd_pkg::SYNC_SECOND);
    add_byte(len16[7:0]);
    add_byte(len16[15:8]);
    for (int i = 0; i < 4; i++) add_byte(tag_byte(2'(i)));
    frame_bytes += 8;
    if (len16 >= rsd_pkg::MIN_FRAME) begin
      for (int unsigned i = 8; i < len; i++) begin
        b = (hdr_fill >= 0 && i < rsd_pkg::MIN_FRAME) ? hdr_fill[7:0] : 8'($urandom);
        add_byte(b);
      end
      frame_bytes += len - 8;
    end
  endtask

  // Start of a long frame: headers and the first n payload bytes only.
  task automatic queue_open_frame(input logic [15:0] len, input int n);
    add_byte(rsd_pkg::SYNC_FIRST);
    add_byte(rsd_pkg::SYNC_SECOND);
    add_byte(len[7:0]);
    add_byte(len[15:8]);
    for (int i = 0; i < 4; i++) add_byte(tag_byte(2'(i)));
    for (int i = 0; i < 12 + n; i++) add_byte(8'($urandom));
    frame_bytes += 20 + n;
  endtask

  // Frame cut short by a wrong tag byte at tag index idx.
  task automatic queue_broken(input int idx, input int bad);
    logic [7:0] b;
    add_byte(rsd_pkg::SYNC_FIRST);
    add_byte(rsd_pkg::SYNC_SECOND);
    add_byte(8'($urandom));
    add_byte(8'($urandom));
    for (int i = 0; i < idx; i++) add_byte(tag_byte(2'(i)));
    if (bad >= 0) begin
      b = bad[7:0];
    end else begin
      b = ($urandom_range(0, 3) == 0) ? rsd_pkg::SYNC_FIRST : 8'($urandom);
    end
    if (b == tag_byte(2'(idx))) b = b ^ 8'h01;
    add_byte(b);
    frame_bytes += 5 + idx;
  endtask

  // Line noise between frames; never forms a sync pair, never ends on a sync byte.
  task automatic queue_noise(input int n);
    logic [7:0] b;
    logic [7:0] prev;
    prev = 8'h00;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 2) == 0) ? rsd_pkg::SYNC_FIRST : 8'($urandom);
      if (prev == rsd_pkg::SYNC_FIRST && b == rsd_pkg::SYNC_SECOND) b = 8'h00;
      if (i == n - 1 && b == rsd_pkg::SYNC_FIRST) b = 8'h5A;
      add_byte(b);
      prev = b;
    end
  endtask

  // byte source
  always @(negedge clk_i) begin : drive_bytes
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    if (rst_ni) begin
      if (in_taken) begin
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) in_no_idle = ~in_no_idle;
        in_gap = in_no_idle ? 0 : $urandom_range(0, 5);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_bytes.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = next_byte();
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
  end

  // result sink
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_no_idle = ~out_no_idle;
        out_stall = out_no_idle ? 0 : $urandom_range(0, 5);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watch_ports
    deframe_result_t got;
    deframe_result_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        bytes_taken++;
        parse_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken      = 1'b1;
        got.kind       = m_axis_tuser[1:0];
        got.first_mark = m_axis_tuser[2];
        got.last_mark  = m_axis_tlast;
        got.data       = m_axis_tdata[7:0];
        got.seq        = m_axis_tdata[23:8];
        got.ptype      = m_axis_tdata[30:24];
        got.stamp      = m_axis_tdata[62:31];
        got.ssrc       = m_axis_tdata[94:63];
        got.plen       = m_axis_tdata[110:95];
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected, kind", 32'(got.kind), 32'h0);
        end else begin
          want = next_result();
          if (got.kind != want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
          if (got.data != want.data) report_mismatch("payload_byte", 32'(got.data), 32'(want.data));
          if (got.first_mark != want.first_mark)
            report_mismatch("first_flag", 32'(got.first_mark), 32'(want.first_mark));
          if (got.last_mark != want.last_mark)
            report_mismatch("last_flag", 32'(got.last_mark), 32'(want.last_mark));
          if (got.seq != want.seq) report_mismatch("sequence_number", 32'(got.seq), 32'(want.seq));
          if (got.ptype != want.ptype)
            report_mismatch("payload_type", 32'(got.ptype), 32'(want.ptype));
          if (got.stamp != want.stamp) report_mismatch("time_stamp", got.stamp, want.stamp);
          if (got.ssrc != want.ssrc) report_mismatch("source_id", got.ssrc, want.ssrc);
          if (got.plen != want.plen)
            report_mismatch("payload_length", 32'(got.plen), 32'(want.plen));
          if (want.kind <= rsd_pkg::KIND_ERROR) kind_count[want.kind]++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d bytes queued and %0d results owed",
               cycle_count, pending_bytes.size(), expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int stop_at;
    int pick;
    int hdr_fill;
    sync_q     = 1'b0;
    in_frame_q = 1'b0;
    pos_q      = '0;
    len_q      = '0;
    seq_q      = '0;
    ptype_q    = '0;
    stamp_q    = '0;
    source_q   = '0;

    // repeated sync byte, then a sync byte followed by something else
    add_byte(rsd_pkg::SYNC_FIRST);
    add_byte(rsd_pkg::SYNC_FIRST);
    add_byte(rsd_pkg::SYNC_SECOND);
    add_byte(8'h00);
    queue_frame(21, 0);                   // single payload byte, first and last together
    queue_frame(rsd_pkg::MIN_FRAME, 255); // header-only frame, every header field at its top
    queue_frame(0, -1);                   // length errors
    queue_frame(19, -1);
    for (int i = 0; i < 4; i++) queue_broken(i, -1);
    // sync byte as the bad tag byte must not restart the hunt
    queue_broken(2, rsd_pkg::SYNC_FIRST);
    add_byte(rsd_pkg::SYNC_SECOND);
    add_byte(8'h00);
    queue_frame(24, -1);

    stop_at = frame_bytes + RANDOM_BYTES;
    while (frame_bytes < stop_at) begin
      pick = $urandom_range(0, 99);
      hdr_fill = ($urandom_range(0, 9) != 0) ? -1 : ($urandom_range(0, 1) ? 255 : 0);
      if (pick < 6) begin
        queue_frame($urandom_range(0, 19), -1);
      end else if (pick < 14) begin
        queue_frame(rsd_pkg::MIN_FRAME, hdr_fill);
      end else if (pick < 20) begin
        queue_frame(21, hdr_fill);
      end else if (pick < 24) begin
        queue_frame($urandom_range(256, 300), hdr_fill);
      end else if (pick < 70) begin
        queue_frame($urandom_range(22, 60), hdr_fill);
      end else if (pick < 85) begin
        queue_broken($urandom_range(0, 3), -1);
      end else begin
        queue_noise($urandom_range(1, 8));
      end
      if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 4));
    end
    // start of a frame of the largest length drives the top bits of payload_length
    queue_open_frame(16'hFFFF, 24);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d stream bytes (%0d in frames or cut-off frames), checked %0d results",
             bytes_taken, frame_bytes, results_checked);
    $display("Results: %0d payload bytes, %0d header-only frames, %0d length errors",
             kind_count[0], kind_count[1], kind_count[2]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
